@@ rtl/foc_cpt_pkg.sv @@
// ----------------------------------------------------------------------------
// Clarke/Park transform package
// Shared constants, the quarter-wave sine table and fixed-point helpers.
// ----------------------------------------------------------------------------
package foc_cpt_pkg;

    localparam int SAMPLE_WIDTH     = 16;
    localparam int ANGLE_WIDTH      = 16;
    // The table depth is a power of two.
    localparam int SINE_TABLE_DEPTH = 256;
    localparam int OFFSET_WIDTH     = $clog2(SINE_TABLE_DEPTH);
    localparam int PHASE_WIDTH      = OFFSET_WIDTH + 2;
    localparam int PROD_WIDTH       = 2 * SAMPLE_WIDTH;
    localparam int ACC_WIDTH        = 2 * SAMPLE_WIDTH + 2;
    localparam int SUM_WIDTH        = SAMPLE_WIDTH + 2;
    localparam int FRAC_BITS        = 15;

    localparam logic signed [SAMPLE_WIDTH-1:0] INV_SQRT3_Q15 = SAMPLE_WIDTH'(18919);

    localparam longint SIN_COEF [0:5] = '{
        64'sd1686629713, -64'sd693598669, 64'sd85569306,
        -64'sd5026995, 64'sd172272, -64'sd3864
    };

    typedef logic [SAMPLE_WIDTH-2:0] sine_rom_t [0:SINE_TABLE_DEPTH];

    function automatic sine_rom_t build_sine_rom();
        sine_rom_t rom;
        longint    x;
        longint    x2;
        longint    acc;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x   = (longint'(k) <<< 30) / SINE_TABLE_DEPTH;
            x2  = (x * x) >>> 30;
            acc = SIN_COEF[5];
            for (int i = 4; i >= 0; i--) begin
                acc = SIN_COEF[i] + ((acc * x2) >>> 30);
            end
            acc = (((acc * x) >>> 30) + 64'sd16384) >>> 15;
            if (acc < 0) begin
                acc = 0;
            end
            if (acc > 32767) begin
                acc = 32767;
            end
            rom[k] = acc[SAMPLE_WIDTH-2:0];
        end
        return rom;
    endfunction

    localparam sine_rom_t SINE_ROM = build_sine_rom();

    // Signed sine at a phase of 4*SINE_TABLE_DEPTH steps per turn.
    function automatic logic signed [SAMPLE_WIDTH-1:0] sine_at_phase(
        input logic [PHASE_WIDTH-1:0] phase
    );
        logic [1:0]              quad;
        logic [OFFSET_WIDTH-1:0] offs;
        logic [OFFSET_WIDTH:0]   idx;
        logic [SAMPLE_WIDTH-1:0] mag;
        quad = phase[PHASE_WIDTH-1 -: 2];
        offs = phase[OFFSET_WIDTH-1:0];
        if (quad[0]) begin
            idx = (OFFSET_WIDTH+1)'(SINE_TABLE_DEPTH) - {1'b0, offs};
        end else begin
            idx = {1'b0, offs};
        end
        mag = {1'b0, SINE_ROM[idx]};
        return quad[1] ? -$signed(mag) : $signed(mag);
    endfunction

    // Divide by 2^15 rounding half up, then saturate to the sample range.
    function automatic logic signed [SAMPLE_WIDTH-1:0] round_sat(
        input logic signed [ACC_WIDTH-1:0] v
    );
        logic signed [ACC_WIDTH-1:0] t;
        t = (v + ACC_WIDTH'(1 << (FRAC_BITS - 1))) >>> FRAC_BITS;
        if (t > ACC_WIDTH'((1 << (SAMPLE_WIDTH - 1)) - 1)) begin
            return {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
        end else if (t < -ACC_WIDTH'(1 << (SAMPLE_WIDTH - 1))) begin
            return {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
        end
        return t[SAMPLE_WIDTH-1:0];
    endfunction

endpackage

@@ rtl/foc_clarke_park_transforms.sv @@
// ----------------------------------------------------------------------------
// Clarke, Park and inverse Park transforms
// Five-stage pipeline: table lookup, products, rounding, Park products, output.
// ----------------------------------------------------------------------------
// Path: an input transaction loads the first of the five stage registers on the
// clock edge that accepts it and passes through the others in order to m_tvalid.
// Throughput: one transaction per cycle while m_tready is high; each stage advances
// on its own, so bubbles close up while the output register is stalled.
// Reset: aresetn low clears all stage valid bits; data registers are not reset.
module foc_clarke_park_transforms (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // phase_a_current, phase_b_current, rotor_angle, volt_cmd_d, volt_cmd_q
    input  logic [79:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // cur_alpha, cur_beta, cur_d, cur_q, volt_alpha, volt_beta
    output logic [95:0] m_tdata
);

    localparam int SW = foc_cpt_pkg::SAMPLE_WIDTH;
    localparam int PW = foc_cpt_pkg::PROD_WIDTH;
    localparam int AW = foc_cpt_pkg::ACC_WIDTH;
    localparam int NS = 5;

    logic [NS-1:0] valid_reg;
    logic [NS-1:0] en;

    logic signed [SW-1:0] phase_a_current;
    logic signed [SW-1:0] phase_b_current;
    logic [foc_cpt_pkg::ANGLE_WIDTH-1:0] rotor_angle;
    logic signed [SW-1:0] volt_cmd_d;
    logic signed [SW-1:0] volt_cmd_q;

    assign phase_a_current = s_tdata[15:0];
    assign phase_b_current = s_tdata[31:16];
    assign rotor_angle     = s_tdata[47:32];
    assign volt_cmd_d      = s_tdata[63:48];
    assign volt_cmd_q      = s_tdata[79:64];

    assign en[NS-1] = !valid_reg[NS-1] || m_tready;
    for (genvar k = 0; k < NS - 1; k++) begin : g_en
        assign en[k] = !valid_reg[k] || en[k+1];
    end
    assign s_tready = en[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < NS; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    // Stage 0: sine/cosine lookup and Clarke sum.
    logic signed [SW-1:0] sn0;
    logic signed [SW-1:0] cs0;
    logic signed [SW-1:0] alpha0_reg;
    logic signed [SW-1:0] vd0_reg;
    logic signed [SW-1:0] vq0_reg;
    logic signed [foc_cpt_pkg::SUM_WIDTH-1:0] sum0_reg;
    logic signed [foc_cpt_pkg::SUM_WIDTH-1:0] sum0_next;

    foc_cpt_sincos u_sincos (
        .aclk    (aclk),
        .en      (en[0]),
        .angle   (rotor_angle),
        .sin_reg (sn0),
        .cos_reg (cs0)
    );

    assign sum0_next = foc_cpt_pkg::SUM_WIDTH'(phase_a_current)
                     + (foc_cpt_pkg::SUM_WIDTH'(phase_b_current) <<< 1);

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            alpha0_reg <= phase_a_current;
            vd0_reg    <= volt_cmd_d;
            vq0_reg    <= volt_cmd_q;
            sum0_reg   <= sum0_next;
        end
    end

    // Stage 1: beta product and inverse Park products.
    logic signed [AW-1:0] beta_prod1_reg;
    logic signed [PW-1:0] vdcs1_reg;
    logic signed [PW-1:0] vqsn1_reg;
    logic signed [PW-1:0] vdsn1_reg;
    logic signed [PW-1:0] vqcs1_reg;
    logic signed [SW-1:0] alpha1_reg;
    logic signed [SW-1:0] sn1_reg;
    logic signed [SW-1:0] cs1_reg;

    always_ff @(posedge aclk) begin
        if (en[1]) begin
            beta_prod1_reg <= AW'(sum0_reg) * AW'(foc_cpt_pkg::INV_SQRT3_Q15);
            vdcs1_reg      <= vd0_reg * cs0;
            vqsn1_reg      <= vq0_reg * sn0;
            vdsn1_reg      <= vd0_reg * sn0;
            vqcs1_reg      <= vq0_reg * cs0;
            alpha1_reg     <= alpha0_reg;
            sn1_reg        <= sn0;
            cs1_reg        <= cs0;
        end
    end

    // Stage 2: round and saturate beta and the voltages.
    logic signed [SW-1:0] beta2_reg;
    logic signed [SW-1:0] valpha2_reg;
    logic signed [SW-1:0] vbeta2_reg;
    logic signed [SW-1:0] alpha2_reg;
    logic signed [SW-1:0] sn2_reg;
    logic signed [SW-1:0] cs2_reg;

    always_ff @(posedge aclk) begin
        if (en[2]) begin
            beta2_reg   <= foc_cpt_pkg::round_sat(beta_prod1_reg);
            valpha2_reg <= foc_cpt_pkg::round_sat(AW'(vdcs1_reg) - AW'(vqsn1_reg));
            vbeta2_reg  <= foc_cpt_pkg::round_sat(AW'(vdsn1_reg) + AW'(vqcs1_reg));
            alpha2_reg  <= alpha1_reg;
            sn2_reg     <= sn1_reg;
            cs2_reg     <= cs1_reg;
        end
    end

    // Stage 3: Park products.
    logic signed [PW-1:0] acs3_reg;
    logic signed [PW-1:0] bsn3_reg;
    logic signed [PW-1:0] bcs3_reg;
    logic signed [PW-1:0] asn3_reg;
    logic signed [SW-1:0] alpha3_reg;
    logic signed [SW-1:0] beta3_reg;
    logic signed [SW-1:0] valpha3_reg;
    logic signed [SW-1:0] vbeta3_reg;

    always_ff @(posedge aclk) begin
        if (en[3]) begin
            acs3_reg    <= alpha2_reg * cs2_reg;
            bsn3_reg    <= beta2_reg * sn2_reg;
            bcs3_reg    <= beta2_reg * cs2_reg;
            asn3_reg    <= alpha2_reg * sn2_reg;
            alpha3_reg  <= alpha2_reg;
            beta3_reg   <= beta2_reg;
            valpha3_reg <= valpha2_reg;
            vbeta3_reg  <= vbeta2_reg;
        end
    end

    // Stage 4: output register.
    logic [95:0] m_tdata_reg;
    logic [95:0] m_tdata_next;

    always_comb begin
        m_tdata_next[15:0]  = alpha3_reg;
        m_tdata_next[31:16] = beta3_reg;
        m_tdata_next[47:32] = foc_cpt_pkg::round_sat(AW'(acs3_reg) + AW'(bsn3_reg));
        m_tdata_next[63:48] = foc_cpt_pkg::round_sat(AW'(bcs3_reg) - AW'(asn3_reg));
        m_tdata_next[79:64] = valpha3_reg;
        m_tdata_next[95:80] = vbeta3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en[4]) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    assign m_tvalid = valid_reg[NS-1];
    assign m_tdata  = m_tdata_reg;

`ifndef SYNTHESIS
    a_full_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (&valid_reg && !m_tready) |-> !s_tready)
        else $error("Input accepted while the pipeline is full and stalled.");

    a_occupancy_step: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> ($countones(valid_reg) <= $past($countones(valid_reg)) + 1)
              && ($countones(valid_reg) + 1 >= $past($countones(valid_reg))))
        else $error("Pipeline occupancy changed by more than one transaction.");

    a_sincos_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg[1] |-> (sn1_reg != '0 || cs1_reg != '0))
        else $error("Sine and cosine are both zero.");
`endif

endmodule

@@ rtl/foc_cpt_sincos.sv @@
// ----------------------------------------------------------------------------
// Sine/cosine lookup
// Registered sine and cosine of an angle from the quarter-wave table.
// ----------------------------------------------------------------------------
module foc_cpt_sincos (
    input  logic                                      aclk,
    input  logic                                      en,
    input  logic [foc_cpt_pkg::ANGLE_WIDTH-1:0]       angle,
    output logic signed [foc_cpt_pkg::SAMPLE_WIDTH-1:0] sin_reg,
    output logic signed [foc_cpt_pkg::SAMPLE_WIDTH-1:0] cos_reg
);

    logic [foc_cpt_pkg::PHASE_WIDTH-1:0]         phase;
    logic [foc_cpt_pkg::PHASE_WIDTH-1:0]         phase_cos;
    logic signed [foc_cpt_pkg::SAMPLE_WIDTH-1:0] sin_next;
    logic signed [foc_cpt_pkg::SAMPLE_WIDTH-1:0] cos_next;

    assign phase     = angle[foc_cpt_pkg::ANGLE_WIDTH-1 -: foc_cpt_pkg::PHASE_WIDTH];
    assign phase_cos = phase + foc_cpt_pkg::PHASE_WIDTH'(foc_cpt_pkg::SINE_TABLE_DEPTH);
    assign sin_next  = foc_cpt_pkg::sine_at_phase(phase);
    assign cos_next  = foc_cpt_pkg::sine_at_phase(phase_cos);

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_reg <= sin_next;
            cos_reg <= cos_next;
        end
    end

endmodule
